/* hdl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, types and character classes for the line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAX_TOKENS = 12;
    localparam int LINE_LEN   = 256;

    localparam int POS_W  = $clog2(LINE_LEN);
    localparam int TC_W   = $clog2(MAX_TOKENS + 1);
    localparam int SLOT_W = 4;
    localparam int OPOS_W = 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_LABEL  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_OPCODE = SLOT_W'(1);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_FIRST,
        PH_PLAIN,
        PH_WORD,
        PH_COMMA,
        PH_HALT
    } phase_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [OPOS_W-1:0] position;
        logic              status;
        logic              last;
    } res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_stop(input logic [7:0] c);
        return (c == CH_HASH) || (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
    endfunction

endpackage

/* hdl/slt_scan.sv */
// ----------------------------------------------------------------------------
// slt_scan
// Line scanner: per-line state and the update for one character, giving up
// to two results (token report, then line status) per character.
// ----------------------------------------------------------------------------
module slt_scan
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ch,
    output logic [1:0]        res_cnt,
    output slt_pkg::res_t     res0,
    output slt_pkg::res_t     res1
);
    import slt_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic              skip_reg, skip_next;
    logic [POS_W-1:0]  fts_reg, fts_next;
    logic              label_reg, label_next;
    logic              err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            pos_reg   <= '0;
            tc_reg    <= '0;
            skip_reg  <= 1'b0;
            fts_reg   <= '0;
            label_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tc_reg    <= tc_next;
            skip_reg  <= skip_next;
            fts_reg   <= fts_next;
            label_reg <= label_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        logic              stop;
        logic              eol;
        logic              tk_v;
        logic [SLOT_W-1:0] tk_slot;
        logic [POS_W-1:0]  tk_pos;
        logic [TC_W:0]     tc_inc;
        logic              rec;
        logic              fault;
        logic              a_v;
        logic              err_f;
        res_t              tok;
        res_t              st;

        stop       = is_stop(ch);
        eol        = stop || (pos_reg == POS_W'(LINE_LEN - 1));
        phase_next = phase_reg;
        tc_next    = tc_reg;
        skip_next  = skip_reg;
        fts_next   = fts_reg;
        label_next = label_reg;
        err_next   = err_reg;
        pos_next   = pos_reg + POS_W'(1);
        tk_v       = 1'b0;
        tk_slot    = SLOT_W'(tc_reg);
        tk_pos     = pos_reg;
        rec        = 1'b0;
        fault      = 1'b0;
        tc_inc     = {1'b0, tc_reg} + (TC_W + 1)'(1);

        if (!stop)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (ch == CH_COMMA || ch == CH_COLON)
                        fault = 1'b1;
                    else if (!is_blank(ch))
                    begin
                        fts_next   = pos_reg;
                        phase_next = PH_FIRST;
                    end
                end
                PH_FIRST:
                begin
                    if (ch == CH_COLON)
                    begin
                        tk_v       = 1'b1;
                        tk_slot    = SLOT_LABEL;
                        tk_pos     = fts_reg;
                        label_next = 1'b1;
                        tc_next    = TC_W'(1);
                        phase_next = PH_PLAIN;
                    end
                    else if (is_blank(ch) || ch == CH_COMMA)
                    begin
                        tk_v       = 1'b1;
                        tk_slot    = SLOT_OPCODE;
                        tk_pos     = fts_reg;
                        tc_next    = TC_W'(2);
                        phase_next = PH_PLAIN;
                        // comma right after the opcode is a stray comma
                        fault      = (ch == CH_COMMA);
                    end
                end
                PH_PLAIN:
                begin
                    if (ch == CH_COMMA || ch == CH_COLON)
                        fault = 1'b1;
                    else if (!is_blank(ch))
                        rec = 1'b1;
                end
                PH_WORD:
                begin
                    if (is_blank(ch) || ch == CH_COMMA)
                    begin
                        skip_next = 1'b0;
                        if (label_reg && tc_reg == TC_W'(2))
                        begin
                            phase_next = PH_PLAIN;
                            fault      = (ch == CH_COMMA);
                        end
                        else
                        begin
                            phase_next = PH_COMMA;
                            skip_next  = (ch == CH_COMMA);
                        end
                    end
                end
                PH_COMMA:
                begin
                    if (ch == CH_COMMA)
                        skip_next = 1'b1;
                    else if (!is_blank(ch))
                    begin
                        if (ch == CH_COLON || !skip_reg)
                            fault = 1'b1;
                        else
                        begin
                            skip_next = 1'b0;
                            rec       = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (rec)
        begin
            tk_v       = 1'b1;
            tk_slot    = SLOT_W'(tc_reg);
            tk_pos     = pos_reg;
            tc_next    = tc_inc[TC_W-1:0];
            phase_next = (tc_inc >= (TC_W + 1)'(MAX_TOKENS)) ? PH_HALT : PH_WORD;
        end

        if (fault)
        begin
            err_next   = 1'b1;
            phase_next = PH_HALT;
        end

        // at line end an open first token is the opcode
        a_v   = tk_v || (eol && phase_next == PH_FIRST);
        err_f = err_next || (phase_next == PH_COMMA && skip_next);

        tok.kind     = KIND_TOKEN;
        tok.slot     = tk_v ? tk_slot : SLOT_OPCODE;
        tok.position = OPOS_W'(tk_v ? tk_pos : fts_next);
        tok.status   = 1'b0;
        tok.last     = !eol;

        st.kind      = KIND_STATUS;
        st.slot      = '0;
        st.position  = '0;
        st.status    = err_f;
        st.last      = 1'b1;

        res0 = tok;
        res1 = st;
        if (a_v)
            res_cnt = eol ? 2'd2 : 2'd1;
        else if (eol)
        begin
            res0    = st;
            res_cnt = 2'd1;
        end
        else
            res_cnt = 2'd0;

        if (eol)
        begin
            pos_next   = '0;
            phase_next = PH_LEAD;
            tc_next    = '0;
            skip_next  = 1'b0;
            fts_next   = '0;
            label_next = 1'b0;
            err_next   = 1'b0;
        end
    end

endmodule

/* hdl/slt_rfifo.sv */
// ----------------------------------------------------------------------------
// slt_rfifo
// Result queue: takes up to two results a cycle, hands out one a cycle on pop.
// ----------------------------------------------------------------------------
module slt_rfifo
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 push_cnt,
    input  slt_pkg::res_t              push0,
    input  slt_pkg::res_t              push1,
    input  logic                       pop,
    output slt_pkg::res_t              head,
    output logic                       room2,
    output logic [slt_pkg::FIFO_CW-1:0] cnt
);
    import slt_pkg::*;

    res_t                mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]  wr_reg, wr_next;
    logic [FIFO_PW-1:0]  rd_reg, rd_next;
    logic [FIFO_CW-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = wr_reg + FIFO_PW'(push_cnt);
        rd_next  = rd_reg + FIFO_PW'(pop);
        cnt_next = cnt_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_reg + FIFO_PW'(1)] <= push1;
    end

    assign head  = mem[rd_reg];
    assign room2 = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign cnt   = cnt_reg;

endmodule

/* hdl/script_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// script_line_tokenizer
// Splits script text, one character per item, into line tokens and reports
// each token start and the status of every line.
// ----------------------------------------------------------------------------
//  channel   ports                                       direction
//  input     in_valid, in_ready, char_in                 in
//  output    out_valid, out_ready, out_kind, slot,       out
//            position, status, last
//
// One character per cycle while the queue has room for two results: the
// character register feeds the scanner, whose results go into a registered
// four-entry result queue. A character that ends a line with an open token
// gives two results, which the single output port drains at one per cycle
// while out_ready is high. Reset puts the scanner at the start of a line with
// nothing queued. Output stalls back up through the queue to in_ready.
// ----------------------------------------------------------------------------
module script_line_tokenizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_kind,
    output logic [3:0] slot,
    output logic [7:0] position,
    output logic       status,
    output logic       last
);
    import slt_pkg::*;

    logic                vld_reg;
    logic [7:0]          char_reg;
    logic                step;
    logic                room2;
    logic [1:0]          res_cnt;
    logic [1:0]          push_cnt;
    res_t                res0;
    res_t                res1;
    res_t                head;
    logic [FIFO_CW-1:0]  fifo_cnt;
    logic                pop;

    assign step     = vld_reg && room2;
    assign in_ready = !vld_reg || step;
    assign push_cnt = step ? res_cnt : 2'd0;
    assign out_valid = (fifo_cnt != '0);
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            char_reg <= char_in;
    end

    slt_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .ch      (char_reg),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    slt_rfifo u_rfifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (res0),
        .push1    (res1),
        .pop      (pop),
        .head     (head),
        .room2    (room2),
        .cnt      (fifo_cnt)
    );

    assign out_kind = head.kind;
    assign slot     = head.slot;
    assign position = head.position;
    assign status   = head.status;
    assign last     = head.last;

    // hold the character while the queue is too full to take its results
    a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && !step |=> vld_reg && $stable(char_reg))
        else $error("pending character lost or changed");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_STATUS |-> last)
        else $error("line status not marked last");

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_cnt == 2'd2 |-> res0.kind == KIND_TOKEN && res1.kind == KIND_STATUS)
        else $error("two results out of order");

endmodule
